### src/bfr_pkg.sv
// ---------------------------------------------------------------------------
// bfr_pkg: shared types and constants for the byte frame receiver
// Holds the frame size default, register reset values, status codes, the
// controller state type and the command/flag bundles between the modules.
// ---------------------------------------------------------------------------
package bfr_pkg;

  localparam int unsigned DEF_MAX_FRAME_LEN = 64;
  localparam int unsigned HEADER_MIN        = 5;

  localparam logic [7:0] START_BYTE_RST = 8'd170;
  localparam logic [7:0] END_BYTE_RST   = 8'd85;

  // configuration register indexes
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_END_BYTE   = 1'b1;

  typedef enum logic [1:0] {
    ST_BYTE     = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_LEN_ERR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_HUNT,
    S_FRAME,
    S_READ,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic start;        // open a frame with the current byte
    logic store;        // store the current byte into the frame
    logic rd_first;     // start the readout at byte 1
    logic rd_next;      // advance the readout by one byte
    logic load_byte;    // capture the read byte into the output register
    logic load_status;  // capture an error item into the output register
  } cmd_t;

  typedef struct packed {
    logic start_hit;    // current byte matches the start byte
    logic emit;         // current byte closes a good frame
    logic err;          // current byte ends the frame with an error item
    logic out_last;     // output register holds the final item of a run
  } flags_t;

endpackage

### src/bfr_ram.sv
// ---------------------------------------------------------------------------
// bfr_ram: generic single-write, single-read RAM
// One write port and one read port with a registered read data output.
// ---------------------------------------------------------------------------
module bfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/bfr_datapath.sv
// ---------------------------------------------------------------------------
// bfr_datapath: frame storage, checks and output register
// Stores frame bytes, tracks length and checksum parity, evaluates the
// close conditions for each byte and drives the output item registers.
// ---------------------------------------------------------------------------
module bfr_datapath #(
  parameter int unsigned MAX_FRAME_LEN = bfr_pkg::DEF_MAX_FRAME_LEN
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [7:0]        rx_byte,
  input  bfr_pkg::cmd_t     cmd,
  output bfr_pkg::flags_t   flags,
  output logic [7:0]        out_byte,
  output logic [1:0]        status,
  output logic              last
);

  localparam int unsigned AW = $clog2(MAX_FRAME_LEN);
  localparam int unsigned CW = $clog2(MAX_FRAME_LEN + 1);
  localparam int unsigned TW = (CW > 9) ? CW : 9;

  logic [7:0]    start_byte;
  logic [7:0]    end_byte;
  logic [CW-1:0] count;
  logic [7:0]    len;
  logic          parity;
  logic [7:0]    b1;       // most recently stored byte
  logic          b2_lsb;   // bit 0 of the byte before it
  logic [AW-1:0] idx;
  logic [AW-1:0] last_idx;

  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_m2;
  logic [TW-1:0] total;
  logic [TW-1:0] cnt_ext;
  logic          parity_new;
  logic          hdr;
  logic          sum_ok;
  logic          len_eq;
  logic          len_gt;
  logic          ovf;
  bfr_pkg::status_t err_code;

  logic          rd_en;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [7:0]    rdata;

  always_comb begin
    cnt_inc    = count + CW'(1);
    cnt_m2     = count - CW'(2);
    cnt_ext    = TW'(cnt_inc);
    total      = TW'(len) + TW'(bfr_pkg::HEADER_MIN);
    parity_new = parity ^ ((count >= CW'(bfr_pkg::HEADER_MIN)) & b2_lsb);
    hdr        = (cnt_inc >= CW'(bfr_pkg::HEADER_MIN)) && (rx_byte == end_byte);
    len_eq     = hdr && (cnt_ext == total);
    len_gt     = hdr && (cnt_ext > total);
    sum_ok     = (b1 == {7'd0, parity_new});
    ovf        = !len_eq && !len_gt && (cnt_inc == CW'(MAX_FRAME_LEN));
    priority if (len_eq) begin
      err_code = bfr_pkg::ST_BAD_SUM;
    end else if (len_gt) begin
      err_code = bfr_pkg::ST_LEN_ERR;
    end else begin
      err_code = bfr_pkg::ST_OVERFLOW;
    end
    flags.start_hit = (rx_byte == start_byte);
    flags.emit      = len_eq && sum_ok;
    flags.err       = (len_eq && !sum_ok) || len_gt || ovf;
    flags.out_last  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= bfr_pkg::START_BYTE_RST;
      end_byte   <= bfr_pkg::END_BYTE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bfr_pkg::CFG_START_BYTE: start_byte <= cfg_data;
        bfr_pkg::CFG_END_BYTE:   end_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      len    <= '0;
      parity <= 1'b0;
    end else if (cmd.start) begin
      count  <= CW'(1);
      len    <= '0;
      parity <= 1'b0;
    end else if (cmd.store) begin
      count  <= cnt_inc;
      parity <= parity_new;
      if (count == CW'(2)) begin
        len <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      b1 <= rx_byte;
    end else if (cmd.store) begin
      b1       <= rx_byte;
      b2_lsb   <= b1[0];
      last_idx <= cnt_m2[AW-1:0];
    end
    if (cmd.rd_first || cmd.rd_next) begin
      idx <= raddr;
    end
    if (cmd.load_byte) begin
      out_byte <= rdata;
      status   <= bfr_pkg::ST_BYTE;
      last     <= (idx == last_idx);
    end else if (cmd.load_status) begin
      out_byte <= 8'd0;
      status   <= err_code;
      last     <= 1'b1;
    end
  end

  assign rd_en = cmd.rd_first || cmd.rd_next;
  assign raddr = cmd.rd_first ? AW'(1) : idx + AW'(1);
  // the start byte always lands at entry 0
  assign waddr = cmd.start ? AW'(0) : count[AW-1:0];

  bfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_LEN)
  ) u_ram (
    .clk   (clk),
    .wr_en (cmd.start || cmd.store),
    .waddr (waddr),
    .wdata (rx_byte),
    .rd_en (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

### src/bfr_ctrl.sv
// ---------------------------------------------------------------------------
// bfr_ctrl: frame receiver controller
// Sequences hunting, collecting, readout and output handshakes.
// ---------------------------------------------------------------------------
module bfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  bfr_pkg::flags_t  flags,
  output bfr_pkg::cmd_t    cmd
);

  bfr_pkg::state_t state;
  bfr_pkg::state_t state_next;
  logic            acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfr_pkg::S_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == bfr_pkg::S_HUNT) || (state == bfr_pkg::S_FRAME);
    out_valid  = (state == bfr_pkg::S_SHOW);
    acc        = in_valid && in_ready;
    unique case (state)
      bfr_pkg::S_HUNT: begin
        if (acc && flags.start_hit) begin
          cmd.start  = 1'b1;
          state_next = bfr_pkg::S_FRAME;
        end
      end
      bfr_pkg::S_FRAME: begin
        if (acc) begin
          cmd.store = 1'b1;
          priority if (flags.emit) begin
            cmd.rd_first = 1'b1;
            state_next   = bfr_pkg::S_READ;
          end else if (flags.err) begin
            cmd.load_status = 1'b1;
            state_next      = bfr_pkg::S_SHOW;
          end else begin
            state_next = bfr_pkg::S_FRAME;
          end
        end
      end
      bfr_pkg::S_READ: begin
        cmd.load_byte = 1'b1;
        state_next    = bfr_pkg::S_SHOW;
      end
      bfr_pkg::S_SHOW: begin
        if (out_ready) begin
          if (flags.out_last) begin
            state_next = bfr_pkg::S_HUNT;
          end else begin
            cmd.rd_next = 1'b1;
            state_next  = bfr_pkg::S_READ;
          end
        end
      end
      default: state_next = bfr_pkg::S_HUNT;
    endcase
  end

endmodule

### src/byte_frame_receiver_parity_check.sv
// ---------------------------------------------------------------------------
// byte_frame_receiver_parity_check: delimited byte frame receiver
// Hunts for the start byte, stores the frame, checks length and parity
// checksum on the end byte and replays the frame body or one status item.
// ---------------------------------------------------------------------------
//
//   channel   handshake               payload
//   --------  ----------------------  ------------------------------------
//   input     in_valid / in_ready     rx_byte[7:0]
//   output    out_valid / out_ready   out_byte[7:0], status[1:0], last
//   config    cfg_wr_en (no wait)     cfg_index, cfg_data[7:0]
//
// Readout: a good frame replays its body byte by byte, each byte going through
// a RAM read and then the output register, and waits while the output side
// stalls; an error item is shown in the cycle after the byte that closes it.
// Reset: returns to hunting for the start byte and restores the register
// defaults; the frame store needs no clearing since every replayed entry was
// written in the same frame.
// Stalls: input is held off while an item sits in the output register.
// ---------------------------------------------------------------------------
module byte_frame_receiver_parity_check #(
  parameter int unsigned MAX_FRAME_LEN = bfr_pkg::DEF_MAX_FRAME_LEN
) (
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // received byte request
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  // result request
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last
);

  // command and status bundles between controller and datapath
  bfr_pkg::cmd_t   cmd;
  bfr_pkg::flags_t flags;

  // controller: owns both handshakes and sequences the readout
  bfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  // datapath: frame store, length/parity checks, output item register
  bfr_datapath #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx_byte   (rx_byte),
    .cmd       (cmd),
    .flags     (flags),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule

### src/bfr_checker.sv
// ---------------------------------------------------------------------------
// bfr_checker: port-level checks for the byte frame receiver
// Watches the top-level ports and flags handshake and item-format slips.
// ---------------------------------------------------------------------------
module bfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] status,
  input logic       last
);

  // input is never taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) &&
                                   $stable(status) && $stable(last)))
    else $error("stalled result changed");

  // error items carry a zero byte and close the run
  a_err_fmt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != bfr_pkg::ST_BYTE) |-> (last && out_byte == 8'd0))
    else $error("malformed status item");

  // after any taken result the next one needs a fresh read or frame
  a_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result shown without readout gap");

  // after a final item the block is back to taking input
  a_resume: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("input not resumed after final item");

endmodule

bind byte_frame_receiver_parity_check bfr_checker u_bfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .status    (status),
  .last      (last)
);
